[hw/rtl/fpba_pkg.sv]
// fpba_pkg: item structs, command/status structs and codes for the block allocator
// used by fpba_ctrl, fpba_dp and fit_policy_block_allocator; no dependencies
package fpba_pkg;

  // operation codes of an input item
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // placement policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 4'd1;

  // configuration reset values
  localparam logic [1:0] FIT_POLICY_RST  = POL_FIRST;
  localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

  // input item
  typedef struct packed {
    logic        operation;
    logic [3:0]  block_index;
    logic [15:0] amount;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_block;
    logic [15:0] space_left;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_alloc;
    logic limit_zero;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/fpba_ctrl.sv]
// fpba_ctrl: sequencer for the block allocator (accept, scan, finish)
// depends on fpba_pkg for the command and status structs
module fpba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpba_pkg::dp_status_t status,
  output fpba_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // handshake and commands
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.scan_en = (state_r == ST_SCAN);
    cmd.finish  = (state_r == ST_FINISH) && status.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.in_alloc && !status.limit_zero) state_nxt = ST_SCAN;
          else state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

[hw/rtl/fpba_dp.sv]
// fpba_dp: free space table, scan comparator, config registers and output register
// depends on fpba_pkg for item, command and status types and codes
module fpba_dp #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fpba_pkg::in_item_t                  in_item,
  input  fpba_pkg::ctrl_cmd_t                 cmd,
  output fpba_pkg::dp_status_t                status,
  input  logic                                cfg_valid,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fpba_pkg::out_item_t                 out_item
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CW    = (SIZE_BITS > 16) ? SIZE_BITS : 16;
  localparam logic [CW-1:0] SIZE_MAX_EXT = CW'({SIZE_BITS{1'b1}});

  // configuration registers
  logic [1:0] policy_r;
  logic [4:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpba_pkg::FIT_POLICY_RST;
      count_r  <= fpba_pkg::BLOCK_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpba_pkg::CFG_FIT_POLICY:  policy_r <= cfg_wdata[1:0];
        fpba_pkg::CFG_BLOCK_COUNT: count_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // searched block count, capped at the table depth
  logic [CNT_W-1:0] limit;
  always_comb begin
    if (32'(count_r) > NUM_BLOCKS) limit = CNT_W'(NUM_BLOCKS);
    else limit = CNT_W'(count_r);
  end

  // captured item
  logic             op_r;
  logic [3:0]       idx_r;
  logic [CW-1:0]    need_r;
  logic [CNT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_item.operation;
      idx_r   <= in_item.block_index;
      need_r  <= CW'(in_item.amount);
      limit_r <= limit;
    end
  end

  // table storage and per-entry valid bits
  logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_r;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;

  // scan read port
  logic [CNT_W-1:0]     rd_addr_r;
  logic                 issue;
  logic [SIZE_BITS-1:0] rd_q_r;
  logic                 rd_ent_vld_r;
  logic                 rd_vld_r;
  logic                 rd_last_r;
  logic [IDX_W-1:0]     rd_idx_r;

  assign issue = cmd.scan_en && (rd_addr_r < limit_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_q_r <= mem[rd_addr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= issue;
    end
  end

  // read address counter and tags of the word in flight
  always_ff @(posedge clk) begin
    if (cmd.capture) rd_addr_r <= '0;
    else if (issue) rd_addr_r <= rd_addr_r + CNT_W'(1);
    if (issue) begin
      rd_ent_vld_r <= vld_r[rd_addr_r[IDX_W-1:0]];
      rd_idx_r     <= rd_addr_r[IDX_W-1:0];
      rd_last_r    <= (rd_addr_r + CNT_W'(1)) == limit_r;
    end
  end

  // compare stage: one entry a cycle against the running pick
  logic [SIZE_BITS-1:0] room;
  logic                 fits;
  logic                 take;
  logic                 have_r;
  logic [SIZE_BITS-1:0] pick_room_r;
  logic [IDX_W-1:0]     pick_idx_r;

  always_comb begin
    room = rd_ent_vld_r ? rd_q_r : '0;
    fits = CW'(room) >= need_r;
    case (policy_r)
      fpba_pkg::POL_BEST:  take = fits && (!have_r || room <= pick_room_r);
      fpba_pkg::POL_WORST: take = fits && (!have_r || room > pick_room_r);
      default:             take = fits && !have_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      have_r <= 1'b0;
    end else if (rd_vld_r && take) begin
      have_r      <= 1'b1;
      pick_room_r <= room;
      pick_idx_r  <= rd_idx_r;
    end
  end

  // finish: table update and result
  logic [CW-1:0]        amt_clamp;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] left;
  fpba_pkg::out_item_t  res;

  always_comb begin
    amt_clamp = (need_r > SIZE_MAX_EXT) ? SIZE_MAX_EXT : need_r;
    load_ok   = 32'(idx_r) < NUM_BLOCKS;
    left      = pick_room_r - SIZE_BITS'(need_r);
    wr_en     = 1'b0;
    wr_addr   = pick_idx_r;
    wr_data   = left;
    res       = '0;
    if (op_r == fpba_pkg::OP_LOAD) begin
      wr_addr = IDX_W'(idx_r);
      wr_data = SIZE_BITS'(amt_clamp);
      if (load_ok) begin
        wr_en            = cmd.finish;
        res.granted      = 1'b1;
        res.chosen_block = idx_r;
        res.space_left   = 16'(amt_clamp);
      end
    end else if (have_r) begin
      wr_en            = cmd.finish;
      res.granted      = 1'b1;
      res.chosen_block = 4'(pick_idx_r);
      res.space_left   = 16'(left);
    end
  end

  // output register
  logic                out_valid_r;
  fpba_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // status to the controller
  always_comb begin
    status.in_alloc   = (in_item.operation == fpba_pkg::OP_ALLOC);
    status.limit_zero = (limit == '0);
    status.scan_done  = rd_vld_r && rd_last_r;
    status.out_free   = !out_valid_r || !out_stall;
  end

endmodule

[hw/rtl/fit_policy_block_allocator.sv]
// fit_policy_block_allocator: top level joining the sequencer and the datapath
// depends on fpba_pkg, fpba_ctrl and fpba_dp
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_item (operation, block_index, amount)
// out      output     out_valid/out_stall  out_item (granted, chosen_block, space_left)
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// a load item, or a request while block_count is 0, goes from accept straight to finish;
// any other request scans min(block_count, NUM_BLOCKS) entries first, through the single
// table read port feeding one comparator, one entry a cycle
// reset clears per-entry valid bits at once, so the table reads zero with no clearing pass
// the result waits in the output register while out_stall is high; the next item is
// accepted meanwhile and holds in its finish step until that register frees
module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fpba_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fpba_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fpba_pkg::ctrl_cmd_t  cmd;
  fpba_pkg::dp_status_t status;

  // the user must make config writes only while idle (not enforced here), so always take them
  assign cfg_ready = 1'b1;

  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fpba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
